>>> rtl/swd_pkg.sv
// ----------------------------------------------------------------------------
// swd_pkg - stable weight detector shared definitions
// Sample widths, stream word layout, register map and shared helpers.
// ----------------------------------------------------------------------------
package swd_pkg;

    // sample width in bits (16 to 32)
    localparam int SAMPLE_BITS = 24;

    // fixed register widths
    localparam int DELTA_W = 23;
    localparam int BAND_W  = 23;
    localparam int HOLD_W  = 16;
    localparam int TIME_W  = 32;

    // magnitude of a difference, one bit wider than the samples,
    // wide enough to be compared against the threshold registers
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int CMP_W  = (DIFF_W > DELTA_W) ? DIFF_W : DELTA_W;

    // stream words, padded up to whole bytes
    localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + TIME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DELTA_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_STABILITY_BAND  = 2'd1;
    localparam logic [1:0] REG_HOLD_TIME_MS    = 2'd2;

    // reset values
    localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(50);
    localparam logic [BAND_W-1:0]  BAND_RESET  = BAND_W'(20);
    localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(1000);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // configuration register set
    typedef struct packed {
        logic [DELTA_W-1:0] delta_threshold;
        logic [BAND_W-1:0]  stability_band;
        logic [HOLD_W-1:0]  hold_time_ms;
    } t_cfg;

    // one input word, unpacked
    typedef struct packed {
        t_sample             sample;
        t_sample             precise_sample;
        logic [TIME_W-1:0]   now_ms;
        logic                calibration_pause;
    } t_item;

    // one result word
    typedef struct packed {
        t_sample stable_weight;
        t_sample previous_weight;
        logic    increased;
    } t_result;

    // exact absolute difference, one bit wider than the samples
    function automatic logic [CMP_W-1:0] abs_diff(input t_sample a, input t_sample b);
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] mag;
        d   = DIFF_W'(a) - DIFF_W'(b);
        mag = d[DIFF_W-1] ? -d : d;
        return CMP_W'($unsigned(mag));
    endfunction

endpackage

>>> rtl/swd_cfg_regs.sv
// ----------------------------------------------------------------------------
// swd_cfg_regs - configuration registers
// APB-style register file for threshold, band and hold time.
// ----------------------------------------------------------------------------
module swd_cfg_regs
    import swd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_index;

    assign pready  = 1'b1;
    assign w_wr    = psel & penable & pwrite;
    assign w_index = paddr[3:2];

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delta_threshold <= DELTA_RESET;
            r_cfg.stability_band  <= BAND_RESET;
            r_cfg.hold_time_ms    <= HOLD_RESET;
        end else if (w_wr) begin
            case (w_index)
                REG_DELTA_THRESHOLD: r_cfg.delta_threshold <= pwdata[DELTA_W-1:0];
                REG_STABILITY_BAND:  r_cfg.stability_band  <= pwdata[BAND_W-1:0];
                REG_HOLD_TIME_MS:    r_cfg.hold_time_ms    <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // read-back
    always_comb begin
        case (w_index)
            REG_DELTA_THRESHOLD: prdata = APB_DATA_W'(r_cfg.delta_threshold);
            REG_STABILITY_BAND:  prdata = APB_DATA_W'(r_cfg.stability_band);
            REG_HOLD_TIME_MS:    prdata = APB_DATA_W'(r_cfg.hold_time_ms);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/swd_core.sv
// ----------------------------------------------------------------------------
// swd_core - stability decision
// Input word register, detector state and the per-word decision logic.
// ----------------------------------------------------------------------------
module swd_core
    import swd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_out_ready,
    output logic                 o_load,
    output t_result              o_result,
    output logic                 o_stabilizing
);

    // input word register
    logic              r_in_valid;
    t_item             r_item;

    // detector state
    logic              r_stabilizing, n_stabilizing;
    t_sample           r_last_stable, n_last_stable;
    t_sample           r_candidate,   n_candidate;
    logic              r_in_band,     n_in_band;
    logic [TIME_W-1:0] r_band_start,  n_band_start;

    logic [CMP_W-1:0]  w_diff_last;
    logic [CMP_W-1:0]  w_diff_cand;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_keep;
    logic              w_start;
    logic              w_accept;
    logic              w_emit;
    logic              w_advance;

    // differences and elapsed time
    assign w_diff_last = abs_diff(r_item.sample, r_last_stable);
    assign w_diff_cand = abs_diff(r_item.sample, r_candidate);
    assign w_elapsed   = r_item.now_ms - r_band_start;
    assign w_keep      = w_diff_cand <= CMP_W'(i_cfg.stability_band);
    assign w_start     = w_diff_last >= CMP_W'(i_cfg.delta_threshold);

    // a word entering the band counts zero elapsed time
    assign w_accept = r_stabilizing && w_keep &&
                      (r_in_band ? (w_elapsed >= TIME_W'(i_cfg.hold_time_ms))
                                 : (i_cfg.hold_time_ms == '0));
    assign w_emit    = r_in_valid && !r_item.calibration_pause && w_accept;
    assign w_advance = r_in_valid && (!w_emit || i_out_ready);

    assign o_s_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item.sample            <= i_s_tdata[SAMPLE_BITS-1:0];
            r_item.precise_sample    <= i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_item.now_ms            <= i_s_tdata[2*SAMPLE_BITS+TIME_W-1:2*SAMPLE_BITS];
            r_item.calibration_pause <= i_s_tuser;
        end
    end

    // next state
    always_comb begin
        n_stabilizing = r_stabilizing;
        n_last_stable = r_last_stable;
        n_candidate   = r_candidate;
        n_in_band     = r_in_band;
        n_band_start  = r_band_start;
        if (w_advance && !r_item.calibration_pause) begin
            if (!r_stabilizing) begin
                if (w_start) begin
                    n_candidate   = r_item.sample;
                    n_in_band     = 1'b0;
                    n_band_start  = r_item.now_ms;
                    n_stabilizing = 1'b1;
                end
            end else if (w_accept) begin
                n_last_stable = r_item.precise_sample;
                n_stabilizing = 1'b0;
                n_in_band     = 1'b0;
            end else if (w_keep) begin
                if (!r_in_band) begin
                    n_in_band    = 1'b1;
                    n_band_start = r_item.now_ms;
                end
            end else begin
                n_candidate  = r_item.sample;
                n_in_band    = 1'b0;
                n_band_start = r_item.now_ms;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stabilizing <= 1'b0;
            r_last_stable <= '0;
            r_candidate   <= '0;
            r_in_band     <= 1'b0;
            r_band_start  <= '0;
        end else begin
            r_stabilizing <= n_stabilizing;
            r_last_stable <= n_last_stable;
            r_candidate   <= n_candidate;
            r_in_band     <= n_in_band;
            r_band_start  <= n_band_start;
        end
    end

    // result word
    assign o_load                   = w_emit && i_out_ready;
    assign o_result.stable_weight   = r_item.precise_sample;
    assign o_result.previous_weight = r_last_stable;
    assign o_result.increased       = r_item.precise_sample >= r_last_stable;
    assign o_stabilizing            = r_stabilizing;

endmodule

>>> rtl/swd_out_reg.sv
// ----------------------------------------------------------------------------
// swd_out_reg - result register
// Holds one result word for the output stream until it is taken.
// ----------------------------------------------------------------------------
module swd_out_reg
    import swd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_result               i_result,
    output logic                  o_ready,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser
);

    logic    r_valid;
    t_result r_result;

    // free when empty or being drained this cycle
    assign o_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_result.previous_weight, r_result.stable_weight});
    assign o_m_tuser  = r_result.increased;

endmodule

>>> rtl/stable_weight_detector.sv
// ----------------------------------------------------------------------------
// stable_weight_detector - load cell stability detector
// Watches weight words and emits a stable weight once readings settle.
// ----------------------------------------------------------------------------
// path: an input word is held in the input register, its result word in the result register
// throughput: one word per cycle while the output stream does not stall; the input
//   register, state update and result register work on successive words
// reset: synchronous, active low; clears detector state and loads the
//   register defaults
module stable_weight_detector
    import swd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // sample, precise_sample, now_ms (from bit 0 up)
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // calibration_pause
    input  logic                  i_s_tuser,
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // stable_weight, previous_weight (from bit 0 up)
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // increased
    output logic                  o_m_tuser,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_load;
    logic    w_out_ready;
    logic    w_stabilizing;

    // configuration registers
    swd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // decision logic
    swd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_out_ready   (w_out_ready),
        .o_load        (w_load),
        .o_result      (w_result),
        .o_stabilizing (w_stabilizing)
    );

    // result register
    swd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_result   (w_result),
        .o_ready    (w_out_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // a result is never loaded over an untaken one
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_ready)
        else $error("result loaded into full output register");

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_tvalid)
        else $error("loaded result not presented");

    // accepting a stable weight returns the detector to idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !w_stabilizing)
        else $error("detector still stabilizing after acceptance");

    // added/removed flag agrees with the two weights
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser ==
            ($signed(o_m_tdata[SAMPLE_BITS-1:0]) >=
             $signed(o_m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]))))
        else $error("increased flag inconsistent with weights");

endmodule

>>> tb/tb_stable_weight_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_weight_detector - stable weight detector testbench
// Drives weight words through the input stream and checks every result word
// against a predictor of the settling behaviour. The predictor tracks the
// idle and settling states, the candidate weight and the hold timer. Runs
// several threshold settings written over the configuration port, with
// random idling on both streams.
// ----------------------------------------------------------------------------
module tb_stable_weight_detector;
    import swd_pkg::*;

    localparam int     STALL_LIMIT = 2000;
    localparam int     PHASE_WORDS = 300;
    localparam longint W_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint W_MIN = -W_MAX - 1;
    // address with no register behind it, writes there are dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // settling predictor and store of expected result words
    class stable_weight_tracker;
        logic [DELTA_W-1:0] delta_threshold;
        logic [BAND_W-1:0]  stability_band;
        logic [HOLD_W-1:0]  hold_time_ms;
        bit                 settling;
        t_sample            last_weight;
        t_sample            candidate;
        bit                 in_band;
        logic [TIME_W-1:0]  band_start;
        t_result            expected_words[$];
        int unsigned        mismatches;

        function new();
            delta_threshold = DELTA_RESET;
            stability_band  = BAND_RESET;
            hold_time_ms    = HOLD_RESET;
            settling        = 1'b0;
            last_weight     = '0;
            candidate       = '0;
            in_band         = 1'b0;
            band_start      = '0;
            mismatches      = 0;
        endfunction

        function void set_register(input logic [1:0] idx, input logic [31:0] value);
            case (idx)
                REG_DELTA_THRESHOLD: delta_threshold = value[DELTA_W-1:0];
                REG_STABILITY_BAND:  stability_band  = value[BAND_W-1:0];
                REG_HOLD_TIME_MS:    hold_time_ms    = value[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(input logic [1:0] idx);
            case (idx)
                REG_DELTA_THRESHOLD: return 32'(delta_threshold);
                REG_STABILITY_BAND:  return 32'(stability_band);
                REG_HOLD_TIME_MS:    return 32'(hold_time_ms);
                default:             return '0;
            endcase
        endfunction

        // exact magnitude of a difference, one bit wider than a sample
        function logic [SAMPLE_BITS:0] weight_gap(input t_sample a, input t_sample b);
            logic signed [SAMPLE_BITS:0] d;
            d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
            return d[SAMPLE_BITS] ? -d : d;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void flag(input string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, what);
        endfunction

        // accepted input word
        function void note_sample(input t_item it);
            t_result           word;
            logic [TIME_W-1:0] elapsed;
            if (it.calibration_pause)
                return;
            // idle: wait for a big enough move from the last stable weight
            if (!settling) begin
                if (weight_gap(it.sample, last_weight) >= delta_threshold) begin
                    candidate  = it.sample;
                    in_band    = 1'b0;
                    band_start = it.now_ms;
                    settling   = 1'b1;
                end
                return;
            end
            // settling: stay with the candidate or restart around this sample
            if (weight_gap(it.sample, candidate) <= stability_band) begin
                if (!in_band) begin
                    in_band    = 1'b1;
                    band_start = it.now_ms;
                end
            end else begin
                candidate  = it.sample;
                in_band    = 1'b0;
                band_start = it.now_ms;
            end
            elapsed = it.now_ms - band_start;
            if (in_band && elapsed >= hold_time_ms) begin
                word.stable_weight   = it.precise_sample;
                word.previous_weight = last_weight;
                word.increased       = (it.precise_sample >= last_weight);
                expected_words.push_back(word);
                last_weight = it.precise_sample;
                settling    = 1'b0;
                in_band     = 1'b0;
            end
        endfunction

        // accepted result word
        function void check_word(input t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                flag($sformatf("unexpected result word %0d/%0d/%0b",
                    got.stable_weight, got.previous_weight, got.increased));
                return;
            end
            want = expected_words.pop_front();
            if (got.stable_weight !== want.stable_weight
                    || got.previous_weight !== want.previous_weight
                    || got.increased !== want.increased)
                flag($sformatf("result word: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                    want.stable_weight, want.previous_weight, want.increased,
                    got.stable_weight, got.previous_weight, got.increased));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // sample, precise_sample, now_ms (from bit 0 up)
    logic [IN_DATA_W-1:0]  i_s_tdata;
    // calibration_pause
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // stable_weight, previous_weight (from bit 0 up)
    logic [OUT_DATA_W-1:0] o_m_tdata;
    // increased
    logic                  o_m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    stable_weight_tracker sb = new();
    logic [TIME_W-1:0]    clock_ms = '0;
    bit                   eager_source = 1'b0;
    int                   words_sent = 0;
    int                   idle_cycles = 0;

    stable_weight_detector i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // input word monitor
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            it.sample            = i_s_tdata[SAMPLE_BITS-1:0];
            it.precise_sample    = i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            it.now_ms            = i_s_tdata[2*SAMPLE_BITS +: TIME_W];
            it.calibration_pause = i_s_tuser;
            sb.note_sample(it);
        end
    end

    // result word monitor
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.stable_weight   = o_m_tdata[SAMPLE_BITS-1:0];
            got.previous_weight = o_m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            got.increased       = o_m_tuser;
            sb.check_word(got);
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result sink with random back-pressure, sometimes none for a stretch
    initial begin : result_sink
        int stall;
        bit eager_sink;
        eager_sink = 1'b0;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (($urandom & 31) == 0)
                eager_sink = !eager_sink;
            stall = eager_sink ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    function automatic t_sample clamp_weight(input longint v);
        if (v > W_MAX)
            return t_sample'(W_MAX);
        if (v < W_MIN)
            return t_sample'(W_MIN);
        return t_sample'(v);
    endfunction

    // one input word, after a random gap
    task automatic send_item(input t_sample smp, input t_sample precise,
                             input logic [TIME_W-1:0] now, input bit pause);
        int gap;
        gap = eager_source ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_W'({now, precise, smp});
        i_s_tuser  <= pause;
        do @(posedge i_clk); while (!o_s_tready);
        if (!pause)
            words_sent++;
    endtask

    // one configuration transfer, setup then access
    task automatic apb_transfer(input bit wr, input logic [1:0] idx,
                                input logic [31:0] value, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr)
            sb.set_register(idx, value);
    endtask

    task automatic program_registers(input logic [31:0] delta, input logic [31:0] band,
                                     input logic [31:0] hold);
        logic [31:0] readback;
        logic [1:0]  idx;
        apb_transfer(1'b1, REG_DELTA_THRESHOLD, delta, readback);
        apb_transfer(1'b1, REG_STABILITY_BAND, band, readback);
        apb_transfer(1'b1, REG_HOLD_TIME_MS, hold, readback);
        apb_transfer(1'b1, REG_UNUSED, $urandom, readback);
        for (int k = 0; k < 3; k++) begin
            idx = 2'(k);
            apb_transfer(1'b0, idx, '0, readback);
            if (readback !== sb.register_value(idx))
                sb.flag($sformatf("register %0d read %0h, expected %0h",
                    idx, readback, sb.register_value(idx)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop sending and let every expected word come out
    task automatic drain(input int extra);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // a settling run around a target, or a short burst of noise
    task automatic random_burst();
        int      len;
        int      pick;
        longint  band;
        longint  off;
        longint  up;
        longint  dn;
        longint  nudge;
        t_sample base;
        t_sample smp;
        t_sample precise;
        if (($urandom & 3) == 0)
            eager_source = !eager_source;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 4);
            repeat (len)
                send_item(t_sample'($urandom), t_sample'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            return;
        end
        // target: anywhere, or just past (sometimes just short of) the threshold
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
            base = t_sample'($urandom);
        end else begin
            off = longint'(sb.delta_threshold)
                + ((pick == 2) ? longint'(-1) : longint'($urandom_range(0, 200)));
            up  = longint'(sb.last_weight) + off;
            dn  = longint'(sb.last_weight) - off;
            if (up <= W_MAX && (dn < W_MIN || $urandom_range(0, 1)))
                base = t_sample'(up);
            else if (dn >= W_MIN)
                base = t_sample'(dn);
            else
                base = (sb.last_weight < 0) ? t_sample'(W_MAX) : t_sample'(W_MIN);
        end
        band = longint'(sb.stability_band);
        len  = $urandom_range(3, 8);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_item(t_sample'($urandom), t_sample'($urandom), $urandom, 1'b1);
                continue;
            end
            if (i == 0) begin
                smp = base;
            end else if (($urandom & 7) == 0) begin
                nudge = band + 1 + $urandom_range(0, 50);
                smp = clamp_weight(longint'(base) + ($urandom_range(0, 1) ? nudge : -nudge));
            end else begin
                smp = clamp_weight(longint'(base) + longint'($urandom_range(0, 2 * band)) - band);
            end
            if (($urandom & 3) == 0)
                precise = t_sample'($urandom);
            else
                precise = clamp_weight(longint'(smp) + longint'($urandom_range(0, 40)) - 20);
            if ($urandom_range(0, 9) == 0)
                clock_ms = clock_ms + $urandom;
            else
                clock_ms = clock_ms + $urandom_range(sb.hold_time_ms / 4,
                                                     sb.hold_time_ms / 2 + 1);
            send_item(smp, precise, clock_ms, 1'b0);
        end
    endtask

    // stimulus
    initial begin
        int phase_start;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0)
                drain(4);
            case (phase)
                0: begin
                    // default thresholds: threshold edges, band edges, extremes,
                    // pauses and a hold timer that wraps
                    send_item(t_sample'(W_MAX), t_sample'(W_MIN), 32'hFFFF_FFFF, 1'b1);
                    send_item(49, 0, 0, 1'b0);
                    send_item(-50, 0, 10, 1'b0);
                    send_item(-30, 0, 20, 1'b0);
                    send_item(-71, 0, 500, 1'b0);
                    send_item(t_sample'(W_MAX), 0, 600, 1'b0);
                    send_item(t_sample'(W_MAX), 0, 700, 1'b0);
                    send_item(t_sample'(W_MAX - 20), t_sample'(W_MIN), 1699, 1'b0);
                    send_item(t_sample'(W_MAX - 7), 0, 1700, 1'b1);
                    send_item(t_sample'(W_MAX - 17), t_sample'(W_MIN), 1700, 1'b0);
                    send_item(t_sample'(W_MIN + 49), 0, 1800, 1'b0);
                    send_item(t_sample'(W_MAX), 0, 1900, 1'b0);
                    send_item(t_sample'(W_MIN), 0, 2000, 1'b0);
                    send_item(t_sample'(W_MIN), 0, 2100, 1'b0);
                    send_item(t_sample'(W_MIN + 20), t_sample'(W_MAX), 3100, 1'b0);
                    send_item(t_sample'(W_MAX - 50), 0, 32'hFFFF_FE00, 1'b0);
                    send_item(t_sample'(W_MAX - 50), 0, 32'hFFFF_FF00, 1'b0);
                    send_item(t_sample'(W_MAX - 50), t_sample'(W_MAX), 32'h0000_02E7, 1'b0);
                    send_item(t_sample'(W_MAX - 50), t_sample'(W_MAX), 32'h0000_02E8, 1'b0);
                    clock_ms = 32'h0000_02E8;
                end
                1: begin
                    // zero hold: accepted as soon as a sample lands in band
                    program_registers(0, 0, 0);
                    send_item(123, 7, clock_ms, 1'b0);
                    send_item(123, 7, clock_ms, 1'b0);
                    send_item(124, -5, clock_ms, 1'b0);
                    send_item(125, -5, clock_ms, 1'b0);
                    send_item(125, -9, clock_ms, 1'b0);
                end
                2: program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: program_registers(100, 30, 200);
                4: program_registers($urandom_range(0, 4000), $urandom_range(0, 600),
                                     $urandom_range(0, 5000));
                default: program_registers(1, 1, 1);
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
                random_burst();
        end

        drain(8);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
